/* rtl/ec_point_add_scalar_mul_macros.svh */
`ifndef EC_POINT_ADD_SCALAR_MUL_MACROS_SVH
`define EC_POINT_ADD_SCALAR_MUL_MACROS_SVH

// same-cycle implication
`define ECPSM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecpsm assertion failed");

// next-cycle implication
`define ECPSM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecpsm assertion failed");

`endif

/* rtl/ecpsm_pkg.sv */
`timescale 1ns / 1ps
package ecpsm_pkg;

  localparam logic [1:0] CFG_CURVE_A = 2'd0;
  localparam logic [1:0] CFG_PRIME   = 2'd1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  localparam logic [31:0] CURVE_A_RESET = 32'd2;
  localparam logic [31:0] PRIME_RESET   = 32'd97;

  // operands below m
  function automatic logic [63:0] mod_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, m}) ? 64'(s - {1'b0, m}) : s[63:0];
  endfunction

  function automatic logic [63:0] mod_sub(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    return (a >= b) ? (a - b) : (a + (m - b));
  endfunction

endpackage

/* rtl/ecpsm_modred.sv */
`timescale 1ns / 1ps
module ecpsm_modred #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [31:0]            value,
  input  logic [FIELD_WIDTH-1:0] m,
  output logic                   done,
  output logic [FIELD_WIDTH-1:0] res
);

  logic [FIELD_WIDTH-1:0] rem;
  logic [FIELD_WIDTH-1:0] step;
  logic [31:0]            vr;
  logic [5:0]             cnt;
  logic                   run;

  always_comb begin
    step = FIELD_WIDTH'(ecpsm_pkg::mod_add(64'(rem), 64'(rem), 64'(m)));
    if (vr[31]) begin
      step = FIELD_WIDTH'(ecpsm_pkg::mod_add(64'(step), 64'd1, 64'(m)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        vr  <= value;
        cnt <= 6'd32;
        run <= 1'b1;
      end else if (run) begin
        rem <= step;
        vr  <= vr << 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = rem;

endmodule

/* rtl/ecpsm_modmul.sv */
`timescale 1ns / 1ps
module ecpsm_modmul #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [FIELD_WIDTH-1:0] a,
  input  logic [FIELD_WIDTH-1:0] b,
  input  logic [FIELD_WIDTH-1:0] m,
  output logic                   done,
  output logic [FIELD_WIDTH-1:0] res
);

  localparam int CW = $clog2(FIELD_WIDTH + 1);

  logic [FIELD_WIDTH-1:0] acc;
  logic [FIELD_WIDTH-1:0] ar;
  logic [FIELD_WIDTH-1:0] br;
  logic [FIELD_WIDTH-1:0] mr;
  logic [FIELD_WIDTH-1:0] step;
  logic [CW-1:0]          cnt;
  logic                   run;

  always_comb begin
    step = FIELD_WIDTH'(ecpsm_pkg::mod_add(64'(acc), 64'(acc), 64'(mr)));
    if (br[FIELD_WIDTH-1]) begin
      step = FIELD_WIDTH'(ecpsm_pkg::mod_add(64'(step), 64'(ar), 64'(mr)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc <= '0;
        ar  <= a;
        br  <= b;
        mr  <= m;
        cnt <= CW'(FIELD_WIDTH);
        run <= 1'b1;
      end else if (run) begin
        acc <= step;
        br  <= br << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = acc;

endmodule

/* rtl/ecpsm_ptadd.sv */
`timescale 1ns / 1ps
module ecpsm_ptadd #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [FIELD_WIDTH-1:0] px,
  input  logic [FIELD_WIDTH-1:0] py,
  input  logic                   pinf,
  input  logic [FIELD_WIDTH-1:0] qx,
  input  logic [FIELD_WIDTH-1:0] qy,
  input  logic                   qinf,
  input  logic [FIELD_WIDTH-1:0] ca,
  input  logic [FIELD_WIDTH-1:0] m,
  output logic                   done,
  output logic [FIELD_WIDTH-1:0] rx,
  output logic [FIELD_WIDTH-1:0] ry,
  output logic                   rinf
);

  localparam int FW = FIELD_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MWAIT, S_TAN1, S_TAN2, S_TAN3, S_INV0, S_INVB, S_INVR,
    S_INVS2, S_SLOPE, S_SL2, S_XR1, S_XR2, S_YD, S_YR
  } state_t;

  state_t        state;
  state_t        ret;
  logic [FW-1:0] xp, yp, xq, yq;
  logic          ip, iq;
  logic [FW-1:0] num, den, s, invr, base, e, xr;
  logic          mstart;
  logic [FW-1:0] ma, mb;
  logic          mdone;
  logic [FW-1:0] mres;

  function automatic logic [FW-1:0] fadd(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                         input logic [FW-1:0] mm);
    return FW'(ecpsm_pkg::mod_add(64'(a), 64'(b), 64'(mm)));
  endfunction

  function automatic logic [FW-1:0] fsub(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                         input logic [FW-1:0] mm);
    return FW'(ecpsm_pkg::mod_sub(64'(a), 64'(b), 64'(mm)));
  endfunction

  ecpsm_modmul #(.FIELD_WIDTH(FW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .m     (m),
    .done  (mdone),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      done   <= 1'b0;
      mstart <= 1'b0;
    end else begin
      done   <= 1'b0;
      mstart <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            xp    <= px;
            yp    <= py;
            ip    <= pinf;
            xq    <= qx;
            yq    <= qy;
            iq    <= qinf;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ip) begin
            rx    <= xq;
            ry    <= yq;
            rinf  <= iq;
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (iq) begin
            rx    <= xp;
            ry    <= yp;
            rinf  <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (xp == xq) begin
            if (fadd(yp, yq, m) == '0 || yp != yq) begin
              rx    <= '0;
              ry    <= '0;
              rinf  <= 1'b1;
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              mstart <= 1'b1;
              ma     <= xp;
              mb     <= xp;
              ret    <= S_TAN1;
              state  <= S_MWAIT;
            end
          end else begin
            num   <= fsub(yp, yq, m);
            den   <= fsub(xp, xq, m);
            state <= S_INV0;
          end
        end
        S_MWAIT: begin
          if (mdone) begin
            state <= ret;
          end
        end
        S_TAN1: begin
          num   <= fadd(mres, mres, m);
          state <= S_TAN2;
        end
        S_TAN2: begin
          num   <= fadd(num, mres, m);
          state <= S_TAN3;
        end
        S_TAN3: begin
          num   <= fadd(num, ca, m);
          den   <= fadd(yp, yp, m);
          state <= S_INV0;
        end
        S_INV0: begin
          invr  <= FW'(1);
          base  <= den;
          e     <= m - FW'(2);
          state <= S_INVB;
        end
        S_INVB: begin
          if (e == '0) begin
            state <= S_SLOPE;
          end else if (e[0]) begin
            mstart <= 1'b1;
            ma     <= invr;
            mb     <= base;
            ret    <= S_INVR;
            state  <= S_MWAIT;
          end else begin
            mstart <= 1'b1;
            ma     <= base;
            mb     <= base;
            ret    <= S_INVS2;
            state  <= S_MWAIT;
          end
        end
        S_INVR: begin
          invr   <= mres;
          mstart <= 1'b1;
          ma     <= base;
          mb     <= base;
          ret    <= S_INVS2;
          state  <= S_MWAIT;
        end
        S_INVS2: begin
          base  <= mres;
          e     <= e >> 1;
          state <= S_INVB;
        end
        S_SLOPE: begin
          mstart <= 1'b1;
          ma     <= num;
          mb     <= invr;
          ret    <= S_SL2;
          state  <= S_MWAIT;
        end
        S_SL2: begin
          s      <= mres;
          mstart <= 1'b1;
          ma     <= mres;
          mb     <= mres;
          ret    <= S_XR1;
          state  <= S_MWAIT;
        end
        S_XR1: begin
          xr    <= fsub(mres, xp, m);
          state <= S_XR2;
        end
        S_XR2: begin
          xr    <= fsub(xr, xq, m);
          state <= S_YD;
        end
        S_YD: begin
          mstart <= 1'b1;
          ma     <= s;
          mb     <= fsub(xp, xr, m);
          ret    <= S_YR;
          state  <= S_MWAIT;
        end
        S_YR: begin
          rx    <= xr;
          ry    <= fsub(mres, yp, m);
          rinf  <= 1'b0;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/ec_point_add_scalar_mul.sv */
// add: its run time is set by the bit-serial modular multiplier that runs the
//   exponentiation inverse
// scalar multiply: up to 2*SCALAR_WIDTH-2 point additions, plus a scan
// throughput: one item at a time, start is taken again once busy falls
// rst is synchronous; it returns curve_a to 2 and the modulus to 97
// the result strobe done lasts one cycle and the receiver cannot stall it
`timescale 1ns / 1ps
`include "ec_point_add_scalar_mul_macros.svh"
module ec_point_add_scalar_mul #(
  parameter int FIELD_WIDTH  = 32,
  parameter int SCALAR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] p_x,
  input  logic [31:0] p_y,
  input  logic        p_at_infinity,
  input  logic [31:0] q_x,
  input  logic [31:0] q_y,
  input  logic        q_at_infinity,
  input  logic [31:0] scalar,
  output logic        done,
  output logic [31:0] r_x,
  output logic [31:0] r_y,
  output logic        r_at_infinity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int FW = FIELD_WIDTH;
  localparam int SW = SCALAR_WIDTH;
  localparam int IW = (SW > 1) ? $clog2(SW) : 1;
  localparam int MW = 2 * FW + 1;

  typedef enum logic [3:0] {
    T_IDLE, T_RED, T_RWAIT, T_DISP, T_SCAN, T_DBL, T_DWAIT, T_ADDSEL, T_RD, T_SWAIT,
    T_AWAIT, T_OUT
  } state_t;

  state_t        state;
  logic [31:0]   curve_a;
  logic [31:0]   prime_modulus;
  logic [FW-1:0] m;
  logic          opr;
  logic [31:0]   raw_px, raw_py, raw_qx, raw_qy;
  logic          pinf, qinf;
  logic [SW-1:0] k;
  logic [FW-1:0] fa, fpx, fpy, fqx, fqy;
  logic [2:0]    rcnt;
  logic [IW-1:0] idx, top;
  logic [FW-1:0] acc_x, acc_y;
  logic          acc_inf;

  logic          rstart, rdone;
  logic [31:0]   rval;
  logic [FW-1:0] rres;

  logic          pstart, pdone;
  logic [FW-1:0] pa_x, pa_y, pb_x, pb_y;
  logic          pa_inf, pb_inf;
  logic [FW-1:0] pr_x, pr_y;
  logic          pr_inf;

  logic [MW-1:0] mem [SW];
  logic [MW-1:0] rdata;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata;

  assign m         = FW'(prime_modulus);
  assign cfg_ready = 1'b1;
  assign busy      = (state != T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a       <= ecpsm_pkg::CURVE_A_RESET;
      prime_modulus <= ecpsm_pkg::PRIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ecpsm_pkg::CFG_CURVE_A: curve_a       <= cfg_data;
        ecpsm_pkg::CFG_PRIME:   prime_modulus <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rcnt)
      3'd0:    rval = curve_a;
      3'd1:    rval = raw_px;
      3'd2:    rval = raw_py;
      3'd3:    rval = raw_qx;
      default: rval = raw_qy;
    endcase
  end

  ecpsm_modred #(.FIELD_WIDTH(FW)) u_red (
    .clk   (clk),
    .rst   (rst),
    .start (rstart),
    .value (rval),
    .m     (m),
    .done  (rdone),
    .res   (rres)
  );

  ecpsm_ptadd #(.FIELD_WIDTH(FW)) u_add (
    .clk   (clk),
    .rst   (rst),
    .start (pstart),
    .px    (pa_x),
    .py    (pa_y),
    .pinf  (pa_inf),
    .qx    (pb_x),
    .qy    (pb_y),
    .qinf  (pb_inf),
    .ca    (fa),
    .m     (m),
    .done  (pdone),
    .rx    (pr_x),
    .ry    (pr_y),
    .rinf  (pr_inf)
  );

  // base point table
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {pr_x, pr_y, pr_inf};
    mem_re    = 1'b0;
    mem_raddr = idx - IW'(1);
    if (state == T_SCAN && k[idx]) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = {fpx, fpy, 1'b0};
    end else if (state == T_DWAIT && pdone) begin
      mem_we    = 1'b1;
      mem_waddr = idx + IW'(1);
    end
    if (state == T_ADDSEL && idx != '0 && k[idx - IW'(1)]) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      done   <= 1'b0;
      rstart <= 1'b0;
      pstart <= 1'b0;
      rcnt   <= '0;
      idx    <= '0;
      top    <= '0;
    end else begin
      done   <= 1'b0;
      rstart <= 1'b0;
      pstart <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (start) begin
            opr    <= op;
            raw_px <= p_x;
            raw_py <= p_y;
            raw_qx <= q_x;
            raw_qy <= q_y;
            pinf   <= p_at_infinity;
            qinf   <= q_at_infinity;
            k      <= SW'(scalar);
            rcnt   <= '0;
            if (m < FW'(3)) begin
              r_x           <= '0;
              r_y           <= '0;
              r_at_infinity <= 1'b1;
              done          <= 1'b1;
            end else begin
              state <= T_RED;
            end
          end
        end
        T_RED: begin
          rstart <= 1'b1;
          state  <= T_RWAIT;
        end
        T_RWAIT: begin
          if (rdone) begin
            case (rcnt)
              3'd0:    fa  <= rres;
              3'd1:    fpx <= pinf ? '0 : rres;
              3'd2:    fpy <= pinf ? '0 : rres;
              3'd3:    fqx <= qinf ? '0 : rres;
              default: fqy <= qinf ? '0 : rres;
            endcase
            if (rcnt == 3'd4) begin
              state <= T_DISP;
            end else begin
              rcnt  <= rcnt + 3'd1;
              state <= T_RED;
            end
          end
        end
        T_DISP: begin
          if (opr == ecpsm_pkg::OP_ADD) begin
            pa_x   <= fpx;
            pa_y   <= fpy;
            pa_inf <= pinf;
            pb_x   <= fqx;
            pb_y   <= fqy;
            pb_inf <= qinf;
            pstart <= 1'b1;
            state  <= T_AWAIT;
          end else if (k == '0 || pinf) begin
            r_x           <= '0;
            r_y           <= '0;
            r_at_infinity <= 1'b1;
            done          <= 1'b1;
            state         <= T_IDLE;
          end else begin
            idx   <= IW'(SW - 1);
            state <= T_SCAN;
          end
        end
        T_SCAN: begin
          if (k[idx]) begin
            top     <= idx;
            acc_x   <= fpx;
            acc_y   <= fpy;
            acc_inf <= 1'b0;
            idx     <= '0;
            state   <= T_DBL;
          end else begin
            idx <= idx - IW'(1);
          end
        end
        T_DBL: begin
          if (idx == top) begin
            state <= T_ADDSEL;
          end else begin
            pa_x   <= acc_x;
            pa_y   <= acc_y;
            pa_inf <= acc_inf;
            pb_x   <= acc_x;
            pb_y   <= acc_y;
            pb_inf <= acc_inf;
            pstart <= 1'b1;
            state  <= T_DWAIT;
          end
        end
        T_DWAIT: begin
          if (pdone) begin
            acc_x   <= pr_x;
            acc_y   <= pr_y;
            acc_inf <= pr_inf;
            idx     <= idx + IW'(1);
            state   <= T_DBL;
          end
        end
        T_ADDSEL: begin
          if (idx == '0) begin
            state <= T_OUT;
          end else begin
            idx <= idx - IW'(1);
            if (k[idx - IW'(1)]) begin
              state <= T_RD;
            end
          end
        end
        T_RD: begin
          pa_x   <= rdata[MW-1:FW+1];
          pa_y   <= rdata[FW:1];
          pa_inf <= rdata[0];
          pb_x   <= acc_x;
          pb_y   <= acc_y;
          pb_inf <= acc_inf;
          pstart <= 1'b1;
          state  <= T_SWAIT;
        end
        T_SWAIT: begin
          if (pdone) begin
            acc_x   <= pr_x;
            acc_y   <= pr_y;
            acc_inf <= pr_inf;
            state   <= T_ADDSEL;
          end
        end
        T_AWAIT: begin
          if (pdone) begin
            r_x           <= pr_inf ? '0 : 32'(pr_x);
            r_y           <= pr_inf ? '0 : 32'(pr_y);
            r_at_infinity <= pr_inf;
            done          <= 1'b1;
            state         <= T_IDLE;
          end
        end
        T_OUT: begin
          r_x           <= acc_inf ? '0 : 32'(acc_x);
          r_y           <= acc_inf ? '0 : 32'(acc_y);
          r_at_infinity <= acc_inf;
          done          <= 1'b1;
          state         <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  `ECPSM_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `ECPSM_ASSERT_NXT(a_start_busy, clk, rst, start && !busy && m >= FW'(3), busy)
  `ECPSM_ASSERT_IMP(a_inf_zero, clk, rst, done && r_at_infinity, r_x == '0 && r_y == '0)
  `ECPSM_ASSERT_IMP(a_dbl_range, clk, rst, state == T_DBL, idx <= top)

endmodule
